/* src/rtrk4_pkg.sv */
// Shared constants, register indexes and status codes for the radiative temperature step.
package rtrk4_pkg;

    // Default number of fraction bits in a temperature word.
    localparam int TEMP_FRAC_BITS_DEF = 20;

    // Register values after reset.
    localparam logic [31:0] INIT_TEMP_RST = 32'd314572800;
    localparam logic [47:0] RAD_COEF_RST  = 48'd1046048203;
    localparam logic [39:0] HEAT_CAP_RST  = 40'd65536;
    localparam logic [31:0] STEP_TIME_RST = 32'd16777216;
    localparam logic        INT_EN_RST    = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_INIT_TEMP = 3'd0,
        CFG_RAD_COEF  = 3'd1,
        CFG_HEAT_CAP  = 3'd2,
        CFG_STEP_TIME = 3'd3,
        CFG_INT_EN    = 3'd4
    } t_cfg_idx;

    // Step status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INACTIVE  = 3'd1,
        ST_UNSTABLE  = 3'd2,
        ST_REVERSED  = 3'd3,
        ST_OVERSHOOT = 3'd4,
        ST_RUNAWAY   = 3'd5
    } t_status;

endpackage

/* src/radiative_temperature_rk4_step.sv */
// Radiative temperature step: one facet advanced by RK4 on one shared multiplier and divider.
//
// Each input transaction is one time step of a radiating facet. Absorbed and dumped power
// are summed, and the facet temperature is advanced by fourth-order Runge-Kutta towards
// the radiative equilibrium, falling back to equilibrium when the integration misbehaves.
// All arithmetic runs through one 32x32 multiplier (a 64x64 product is built from four
// partial products) and one restoring divider that resolves one quotient bit a cycle
// and saturates at once when the quotient cannot fit. A full integrating step makes five
// T^4 evaluations and four increments, divides by six as a multiplication by a scaled
// reciprocal of three, and forms the emitted-power quotient. A step that falls back to
// equilibrium adds a 32-step bit search when the total power is positive; a runaway step
// disables integration instead. The block accepts no new transaction until the result
// has been taken.
module radiative_temperature_rk4_step
    import rtrk4_pkg::*;
#(
    parameter int TEMP_FRAC_BITS = TEMP_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [40:0] i_absorbed_power,
    input  logic signed [40:0] i_dumped_power,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_current_temperature,
    output logic [31:0]        o_predicted_temperature,
    output logic signed [40:0] o_emitted_power,
    output logic [2:0]         o_step_status
);

    localparam int          T4_SHIFT    = 4 * TEMP_FRAC_BITS - 16;
    localparam logic [60:0] RUNAWAY_LIM = 61'(1000000) << TEMP_FRAC_BITS;
    localparam logic [63:0] INC_MAX     = 64'd1 << 56;
    localparam logic [63:0] EM_MAX      = 64'd1 << 50;
    // Ceiling of 2^62 / 3: exact for a dividend below 2^61 when the product is shifted by 62.
    localparam logic [63:0] THIRD_MUL   = 64'h1555_5555_5555_5556;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL, S_DIVCHK, S_DIV,
        S_R_SQ, S_R_T4, S_R_K, S_R_END,
        S_D1, S_DF, S_INC0, S_INC1,
        S_I1, S_I2, S_I3, S_I4, S_D6, S_OV,
        S_EQ, S_EQ_TRY, S_EQ_CHK,
        S_EM0, S_EM1, S_EM2, S_OUT
    } t_state;

    // Sequencer and return points.
    t_state r_state, r_ret, r_rret, r_iret;

    // Configuration registers.
    logic [47:0] r_k;
    logic [39:0] r_cap;
    logic [31:0] r_dt;

    // Step state and working registers.
    logic [31:0]        r_cur, r_next, r_rt, r_eqt;
    logic               r_active, r_dir, r_dneg, r_out_valid;
    logic signed [41:0] r_ptot;
    logic signed [49:0] r_f;
    logic [47:0]        r_rad;
    logic [4:0]         r_bit;
    logic signed [57:0] r_i1, r_i2, r_i3;
    logic signed [40:0] r_em;
    t_status            r_status;

    // Shared multiplier.
    logic [63:0]  r_ma, r_mb, r_pp;
    logic [1:0]   r_ppsh;
    logic [2:0]   r_mcnt;
    logic [127:0] r_prod;

    // Shared divider.
    logic [63:0] r_rem, r_dlo, r_den, r_quo;
    logic [5:0]  r_dcnt;

    // Saturate a wide signed value to the 41-bit power format.
    function automatic logic signed [40:0] f_sat41(input logic signed [51:0] v);
        logic signed [51:0] hi, lo;
        hi = (52'sd1 <<< 40) - 52'sd1;
        lo = -(52'sd1 <<< 40);
        if (v > hi) return hi[40:0];
        else if (v < lo) return lo[40:0];
        else return v[40:0];
    endfunction

    // Halve with truncation towards zero.
    function automatic logic signed [57:0] f_half(input logic signed [57:0] x);
        logic signed [57:0] s;
        s = x + $signed({57'd0, x[57]});
        return s >>> 1;
    endfunction

    // Stage temperature magnitude, saturated to 32 bits.
    function automatic logic [31:0] f_stage(input logic [31:0] t0, input logic signed [57:0] inc);
        logic signed [58:0] s;
        logic [58:0]        m;
        s = $signed({27'd0, t0}) + 59'(inc);
        m = s[58] ? unsigned'(-s) : unsigned'(s);
        return (|m[58:32]) ? 32'hFFFF_FFFF : m[31:0];
    endfunction

    // True when a value points against the step direction.
    function automatic logic f_opp(input logic down, input logic neg, input logic nz);
        return down ? (!neg && nz) : neg;
    endfunction

    // Operand and result shaping around the shared units.
    logic signed [41:0]  in_sum;
    logic signed [49:0]  ptot_x, rad_x, deriv;
    logic [63:0]         f_mag;
    logic [39:0]         cap1;
    logic [31:0]         dt1;
    logic [31:0]         m_a, m_b;
    logic [127:0]        mul_acc, t4_wide;
    logic [63:0]         t4;
    logic [63:0]         d_sh;
    logic                d_take;
    logic [56:0]         inc_mag;
    logic signed [57:0]  inc_val, i4_adj;
    logic signed [60:0]  sum4, d_val, t0_x, n_sum;
    logic [63:0]         sum_mag;
    logic signed [33:0]  em_d;
    logic [32:0]         em_mag;
    logic [50:0]         em_q;
    logic signed [51:0]  em_val;

    assign in_sum  = 42'(i_absorbed_power) + 42'(i_dumped_power);
    assign ptot_x  = 50'(r_ptot);
    assign rad_x   = $signed({2'b00, r_rad});
    assign deriv   = ptot_x - rad_x;
    assign f_mag   = 64'(unsigned'(r_f[49] ? -r_f : r_f));
    assign cap1    = (r_cap == 40'd0) ? 40'd1 : r_cap;
    assign dt1     = (r_dt == 32'd0) ? 32'd1 : r_dt;

    assign m_a     = r_mcnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign m_b     = r_mcnt[0] ? r_mb[63:32] : r_mb[31:0];
    assign mul_acc = r_prod + ({64'd0, r_pp} << {r_ppsh, 5'd0});
    assign t4_wide = r_prod >> T4_SHIFT;
    assign t4      = (|t4_wide[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : t4_wide[63:0];

    assign d_sh    = {r_rem[62:0], r_dlo[63]};
    assign d_take  = r_rem[63] || (d_sh >= r_den);

    assign inc_mag = (r_quo > INC_MAX) ? INC_MAX[56:0] : r_quo[56:0];
    assign inc_val = r_f[49] ? -$signed({1'b0, inc_mag}) : $signed({1'b0, inc_mag});
    assign i4_adj  = f_opp(r_dir, inc_val[57], inc_val != 58'sd0) ? f_half(inc_val) : inc_val;
    assign sum4    = 61'(r_i1) + (61'(r_i2) <<< 1) + (61'(r_i3) <<< 1) + 61'(i4_adj);
    assign sum_mag = 64'(unsigned'(sum4[60] ? -sum4 : sum4));
    // The sixth of the weighted sum is the product of its half and the reciprocal of three.
    assign d_val   = r_dneg ? -$signed({1'b0, r_prod[121:62]}) : $signed({1'b0, r_prod[121:62]});
    assign t0_x    = $signed({29'd0, r_cur});
    assign n_sum   = t0_x + d_val;

    assign em_d    = $signed({2'b00, r_next}) - $signed({2'b00, r_cur});
    assign em_mag  = 33'(unsigned'(em_d[33] ? -em_d : em_d));
    assign em_q    = (r_quo > EM_MAX) ? EM_MAX[50:0] : r_quo[50:0];
    assign em_val  = r_dneg ? 52'(r_ptot) + $signed({1'b0, em_q})
                            : 52'(r_ptot) - $signed({1'b0, em_q});

    // Sequencer, shared units, step state and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_rret      <= S_IDLE;
            r_iret      <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= RAD_COEF_RST;
            r_cap       <= HEAT_CAP_RST;
            r_dt        <= STEP_TIME_RST;
            r_next      <= INIT_TEMP_RST;
            r_cur       <= INIT_TEMP_RST;
            r_active    <= INT_EN_RST;
            r_status    <= ST_OK;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ptot <= in_sum;
                        if (!r_active) begin
                            r_status    <= ST_INACTIVE;
                            r_em        <= f_sat41(52'(in_sum));
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end else begin
                            r_cur   <= r_next;
                            r_rt    <= r_next;
                            r_rret  <= S_D1;
                            r_state <= S_R_SQ;
                        end
                    end
                end

                // One 32x32 partial product a cycle, accumulated in the following cycle.
                S_MUL: begin
                    if (r_mcnt != 3'd4) begin
                        r_pp   <= 64'(m_a) * 64'(m_b);
                        r_ppsh <= 2'(r_mcnt[1]) + 2'(r_mcnt[0]);
                    end
                    if (r_mcnt != 3'd0) r_prod <= mul_acc;
                    if (r_mcnt == 3'd4) r_state <= r_ret;
                    r_mcnt <= r_mcnt + 3'd1;
                end

                // A quotient that cannot fit saturates at once.
                S_DIVCHK: begin
                    if (r_rem >= r_den) begin
                        r_quo   <= 64'hFFFF_FFFF_FFFF_FFFF;
                        r_state <= r_ret;
                    end else begin
                        r_quo   <= 64'd0;
                        r_state <= S_DIV;
                    end
                end

                // Restoring division, one quotient bit a cycle.
                S_DIV: begin
                    r_rem  <= d_take ? d_sh - r_den : d_sh;
                    r_quo  <= {r_quo[62:0], d_take};
                    r_dlo  <= {r_dlo[62:0], 1'b0};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'd63) r_state <= r_ret;
                end

                // Radiated power k*T^4 of r_rt.
                S_R_SQ: begin
                    r_ma    <= 64'(r_rt);
                    r_mb    <= 64'(r_rt);
                    r_mcnt  <= 3'd0;
                    r_prod  <= 128'd0;
                    r_ret   <= S_R_T4;
                    r_state <= S_MUL;
                end
                S_R_T4: begin
                    r_ma    <= r_prod[63:0];
                    r_mb    <= r_prod[63:0];
                    r_mcnt  <= 3'd0;
                    r_prod  <= 128'd0;
                    r_ret   <= S_R_K;
                    r_state <= S_MUL;
                end
                S_R_K: begin
                    r_ma    <= 64'(r_k);
                    r_mb    <= t4;
                    r_mcnt  <= 3'd0;
                    r_prod  <= 128'd0;
                    r_ret   <= S_R_END;
                    r_state <= S_MUL;
                end
                S_R_END: begin
                    r_rad   <= r_prod[111:64];
                    r_state <= r_rret;
                end

                // First derivative also fixes the direction of the step.
                S_D1: begin
                    r_dir   <= deriv[49];
                    r_f     <= deriv;
                    r_iret  <= S_I1;
                    r_state <= S_INC0;
                end
                S_DF: begin
                    r_f     <= deriv;
                    r_state <= S_INC0;
                end

                // Increment f*dt/C in temperature units.
                S_INC0: begin
                    r_ma    <= f_mag;
                    r_mb    <= 64'(dt1);
                    r_mcnt  <= 3'd0;
                    r_prod  <= 128'd0;
                    r_ret   <= S_INC1;
                    r_state <= S_MUL;
                end
                S_INC1: begin
                    r_rem   <= 64'(r_prod >> (64 - TEMP_FRAC_BITS));
                    r_dlo   <= r_prod[63:0] << TEMP_FRAC_BITS;
                    r_den   <= {cap1, 24'd0};
                    r_dcnt  <= 6'd0;
                    r_ret   <= r_iret;
                    r_state <= S_DIVCHK;
                end

                S_I1: begin
                    r_i1    <= inc_val;
                    r_rt    <= f_stage(r_cur, f_half(inc_val));
                    r_rret  <= S_DF;
                    r_iret  <= S_I2;
                    r_state <= S_R_SQ;
                end
                S_I2: begin
                    r_i2 <= inc_val;
                    if (f_opp(r_dir, inc_val[57], inc_val != 58'sd0)) begin
                        r_status <= ST_UNSTABLE;
                        r_state  <= S_EQ;
                    end else begin
                        r_rt    <= f_stage(r_cur, f_half(inc_val));
                        r_rret  <= S_DF;
                        r_iret  <= S_I3;
                        r_state <= S_R_SQ;
                    end
                end
                S_I3: begin
                    r_i3    <= inc_val;
                    r_rt    <= f_stage(r_cur, inc_val);
                    r_rret  <= S_DF;
                    r_iret  <= S_I4;
                    r_state <= S_R_SQ;
                end

                // Weighted sum divided by six on the shared multiplier.
                S_I4: begin
                    r_dneg  <= sum4[60];
                    r_ma    <= sum_mag >> 1;
                    r_mb    <= THIRD_MUL;
                    r_mcnt  <= 3'd0;
                    r_prod  <= 128'd0;
                    r_ret   <= S_D6;
                    r_state <= S_MUL;
                end
                S_D6: begin
                    if (d_val < -t0_x || d_val > $signed(RUNAWAY_LIM)) begin
                        r_active    <= 1'b0;
                        r_status    <= ST_RUNAWAY;
                        r_em        <= f_sat41(52'(r_ptot));
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else if (f_opp(r_dir, d_val[60], d_val != 61'sd0)) begin
                        r_status <= ST_REVERSED;
                        r_state  <= S_EQ;
                    end else begin
                        r_next  <= (|n_sum[60:32]) ? 32'hFFFF_FFFF : n_sum[31:0];
                        r_rt    <= (|n_sum[60:32]) ? 32'hFFFF_FFFF : n_sum[31:0];
                        r_rret  <= S_OV;
                        r_state <= S_R_SQ;
                    end
                end

                // Overshoot check on the derivative at the new temperature.
                S_OV: begin
                    if (f_opp(r_dir, deriv[49], deriv != 50'sd0)) begin
                        r_status <= ST_OVERSHOOT;
                        r_state  <= S_EQ;
                    end else begin
                        r_status <= ST_OK;
                        r_state  <= S_EM0;
                    end
                end

                // Equilibrium by a bit search from the top bit down, or zero when the total power is not positive.
                S_EQ: begin
                    if (r_ptot[41] || r_ptot == 42'sd0) begin
                        r_next  <= 32'd0;
                        r_state <= S_EM0;
                    end else begin
                        r_eqt   <= 32'd0;
                        r_bit   <= 5'd31;
                        r_state <= S_EQ_TRY;
                    end
                end
                S_EQ_TRY: begin
                    r_rt    <= r_eqt | (32'd1 << r_bit);
                    r_rret  <= S_EQ_CHK;
                    r_state <= S_R_SQ;
                end
                S_EQ_CHK: begin
                    if (rad_x <= ptot_x) r_eqt <= r_rt;
                    if (r_bit == 5'd0) begin
                        r_next  <= (rad_x <= ptot_x) ? r_rt : r_eqt;
                        r_state <= S_EM0;
                    end else begin
                        r_bit   <= r_bit - 5'd1;
                        r_state <= S_EQ_TRY;
                    end
                end

                // Emitted power: P minus C times the change over the step, divided by the step time.
                S_EM0: begin
                    r_dneg  <= em_d[33];
                    r_ma    <= 64'(cap1);
                    r_mb    <= 64'(em_mag);
                    r_mcnt  <= 3'd0;
                    r_prod  <= 128'd0;
                    r_ret   <= S_EM1;
                    r_state <= S_MUL;
                end
                S_EM1: begin
                    r_rem   <= r_prod[103:40];
                    r_dlo   <= {r_prod[39:0], 24'd0};
                    r_den   <= 64'(dt1) << TEMP_FRAC_BITS;
                    r_dcnt  <= 6'd0;
                    r_ret   <= S_EM2;
                    r_state <= S_DIVCHK;
                end
                S_EM2: begin
                    r_em        <= f_sat41(em_val);
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end

                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase

            // Register writes must arrive only while the block is idle; the block itself does not enforce it.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INIT_TEMP: begin
                        r_next <= i_cfg_data[31:0];
                        r_cur  <= i_cfg_data[31:0];
                    end
                    CFG_RAD_COEF:  r_k      <= i_cfg_data[47:0];
                    CFG_HEAT_CAP:  r_cap    <= i_cfg_data[39:0];
                    CFG_STEP_TIME: r_dt     <= i_cfg_data[31:0];
                    CFG_INT_EN:    r_active <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    assign o_in_ready              = (r_state == S_IDLE);
    assign o_out_valid             = r_out_valid;
    assign o_current_temperature   = r_cur;
    assign o_predicted_temperature = r_next;
    assign o_emitted_power         = r_em;
    assign o_step_status           = r_status;

endmodule
